[sv/sdac_pkg.sv]
// Shared types and constants of the slice depth attenuation corrector.
`timescale 1ns / 1ps
package sdac_pkg;

   localparam int PIXELS      = 65536;
   localparam int PIX_W       = $clog2(PIXELS);
   localparam int GAIN_W      = 24;
   localparam int VOXEL_W     = 16;
   localparam int OUT_W       = 24;
   localparam int PCT_W       = 15;
   localparam int CSR_IDX_W   = 8;
   localparam int CSR_DATA_W  = 16;
   localparam int DIV_STEPS   = OUT_W;
   localparam int QUEUE_DEPTH = 32;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);

   localparam logic [GAIN_W-1:0] GAIN_ONE = 24'h800000;
   localparam logic [OUT_W-1:0]  OUT_MAX  = 24'hFFFFFF;

   localparam logic [15:0] THRESHOLD_RESET = 16'd1;
   localparam logic [15:0] DECAY_RESET     = 16'd65470;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_THRESHOLD = 8'd0,
      CSR_DECAY     = 8'd1
   } csr_index_type;

   typedef struct packed {
      logic [VOXEL_W-1:0] voxel_value;
      logic [15:0]        smoothed_value;
      logic [PIX_W-1:0]   pixel_index;
      logic               first_slice;
   } req_type;

   typedef struct packed {
      logic [OUT_W-1:0] corrected_value;
      logic [PCT_W-1:0] attenuation_percent;
   } rsp_type;

   // Hand-off from the gain front end to the divider back end.
   typedef struct packed {
      logic               valid;
      logic [VOXEL_W-1:0] voxel;
      logic [GAIN_W-1:0]  gain;
   } work_type;

   // One divider stage.
   typedef struct packed {
      logic [GAIN_W-1:0] rem;
      logic [OUT_W-1:0]  quo;
      logic [GAIN_W-1:0] divisor;
      logic              lsb;
      logic              sat;
      logic              zero;
      logic [PCT_W-1:0]  pct;
   } div_stage_type;

endpackage

[sv/sdac_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read.
`timescale 1ns / 1ps
module sdac_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // A read at the address being written returns the old contents.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[sv/sdac_front.sv]
// Front end: gain lookup with forwarding, gain decay and write-back.
`timescale 1ns / 1ps
module sdac_front import sdac_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        accept,
   input  req_type     req_data,
   input  logic [15:0] threshold,
   input  logic [15:0] decay_factor,
   output work_type    work
);

   logic              s1_valid_ff;
   req_type           s1_item_ff;
   logic              wr_valid_ff;
   logic [PIX_W-1:0]  wr_addr_ff;
   logic [GAIN_W-1:0] wr_data_ff;
   logic [GAIN_W-1:0] ram_rd_data;
   logic [GAIN_W-1:0] gain;
   logic [GAIN_W+15:0] product;
   logic [GAIN_W-1:0] next_gain_in;

   sdac_ram #(.WIDTH(GAIN_W), .DEPTH(PIXELS)) u_gain_ram (
      .clock   (clock),
      .wr_en   (s1_valid_ff),
      .wr_addr (s1_item_ff.pixel_index),
      .wr_data (next_gain_in),
      .rd_addr (req_data.pixel_index),
      .rd_data (ram_rd_data)
   );

   // The write of the previous cycle is not yet in the read data: forward it.
   always_comb begin
      if (s1_item_ff.first_slice) begin
         gain = GAIN_ONE;
      end else if (wr_valid_ff && (wr_addr_ff == s1_item_ff.pixel_index)) begin
         gain = wr_data_ff;
      end else begin
         gain = ram_rd_data;
      end
      product = gain * decay_factor;
      if (s1_item_ff.smoothed_value > threshold) begin
         next_gain_in = product[GAIN_W+15:16];
      end else begin
         next_gain_in = gain;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         wr_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= accept;
         wr_valid_ff <= s1_valid_ff;
      end
      s1_item_ff <= req_data;
      wr_addr_ff <= s1_item_ff.pixel_index;
      wr_data_ff <= next_gain_in;
   end

   assign work.valid = s1_valid_ff;
   assign work.voxel = s1_item_ff.voxel_value;
   assign work.gain  = gain;

endmodule

[sv/sdac_divider.sv]
// Back end: pipelined restoring divider, one quotient bit per stage.
`timescale 1ns / 1ps
module sdac_divider import sdac_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  work_type work,
   output logic     out_valid,
   output rsp_type  out_data
);

   logic          valid_ff [DIV_STEPS+1];
   div_stage_type stage_ff [DIV_STEPS+1];
   div_stage_type prep_in;
   logic [GAIN_W-1+7:0] pct_product;

   // The quotient overflows 24 bits exactly when voxel/2 reaches the gain.
   always_comb begin
      pct_product     = work.gain * 7'd100;
      prep_in.rem     = {{(GAIN_W-VOXEL_W+1){1'b0}}, work.voxel[VOXEL_W-1:1]};
      prep_in.quo     = '0;
      prep_in.divisor = work.gain;
      prep_in.lsb     = work.voxel[0];
      prep_in.sat     = {{(GAIN_W-VOXEL_W+1){1'b0}}, work.voxel[VOXEL_W-1:1]} >= work.gain;
      prep_in.zero    = (work.voxel == '0) && (work.gain == '0);
      prep_in.pct     = pct_product[PCT_W+14:15];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k <= DIV_STEPS; k++) begin
            valid_ff[k] <= 1'b0;
         end
      end else begin
         valid_ff[0] <= work.valid;
         for (int k = 1; k <= DIV_STEPS; k++) begin
            valid_ff[k] <= valid_ff[k-1];
         end
      end
      stage_ff[0] <= prep_in;
   end

   // Each stage shifts in one numerator bit and tries one subtraction.
   for (genvar k = 1; k <= DIV_STEPS; k++) begin : g_step
      logic [GAIN_W:0] trial;
      logic            fits;
      div_stage_type   next_in;
      always_comb begin
         next_in = stage_ff[k-1];
         trial   = {stage_ff[k-1].rem, (k == 1) ? stage_ff[k-1].lsb : 1'b0};
         fits    = trial >= {1'b0, stage_ff[k-1].divisor};
         if (fits) begin
            next_in.rem = GAIN_W'(trial - {1'b0, stage_ff[k-1].divisor});
         end else begin
            next_in.rem = trial[GAIN_W-1:0];
         end
         next_in.quo = {stage_ff[k-1].quo[OUT_W-2:0], fits};
      end
      always_ff @(posedge clock) begin
         stage_ff[k] <= next_in;
      end
   end

   always_comb begin
      if (stage_ff[DIV_STEPS].zero) begin
         out_data.corrected_value = '0;
      end else if (stage_ff[DIV_STEPS].sat) begin
         out_data.corrected_value = OUT_MAX;
      end else begin
         out_data.corrected_value = stage_ff[DIV_STEPS].quo;
      end
      out_data.attenuation_percent = stage_ff[DIV_STEPS].pct;
   end

   assign out_valid = valid_ff[DIV_STEPS];

endmodule

[sv/slice_depth_attenuation_correct.sv]
// Top level of the slice depth attenuation corrector.
`timescale 1ns / 1ps
// Takes one voxel request per cycle unless full and returns one result per
// request, in order. A request passes the gain RAM read and gain update
// register, one divider input register, then 24 divider stages producing one
// quotient bit per stage, before it is written into the 32-entry result
// queue. Full rises only when 32 requests are in flight or waiting, so with
// results drained the sustained rate is one request per cycle. Back-to-back
// requests to the same pixel are handled by forwarding the gain just written.
// The gain RAM is not cleared: a pixel must be seen on a first slice before
// later slices read it.
module slice_depth_attenuation_correct import sdac_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_push,
   output logic                  req_full,
   input  req_type               req_data,
   output logic                  rsp_empty,
   input  logic                  rsp_pop,
   output rsp_type               rsp_data,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   logic [15:0]            threshold_ff;
   logic [15:0]            decay_ff;
   logic [QUEUE_PTR_W:0]   credits_ff;
   logic [QUEUE_PTR_W:0]   count_ff;
   logic [QUEUE_PTR_W-1:0] wptr_ff;
   logic [QUEUE_PTR_W-1:0] rptr_ff;
   rsp_type                queue_ff [QUEUE_DEPTH];
   logic                   accept;
   logic                   pop;
   logic                   back_valid;
   rsp_type                back_data;
   work_type               work;

   assign accept    = req_push && !req_full;
   assign pop       = rsp_pop && !rsp_empty;
   assign req_full  = credits_ff == (QUEUE_PTR_W+1)'(QUEUE_DEPTH);
   assign rsp_empty = count_ff == '0;
   assign rsp_data  = queue_ff[rptr_ff];
   assign csr_ready = 1'b1;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff <= THRESHOLD_RESET;
         decay_ff     <= DECAY_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_THRESHOLD: threshold_ff <= csr_data;
            CSR_DECAY:     decay_ff     <= csr_data;
            default:       ;
         endcase
      end
   end

   sdac_front u_front (
      .clock        (clock),
      .reset        (reset),
      .accept       (accept),
      .req_data     (req_data),
      .threshold    (threshold_ff),
      .decay_factor (decay_ff),
      .work         (work)
   );

   sdac_divider u_divider (
      .clock     (clock),
      .reset     (reset),
      .work      (work),
      .out_valid (back_valid),
      .out_data  (back_data)
   );

   // Result queue; credits count requests in flight plus results waiting.
   always_ff @(posedge clock) begin
      if (reset) begin
         credits_ff <= '0;
         count_ff   <= '0;
         wptr_ff    <= '0;
         rptr_ff    <= '0;
      end else begin
         credits_ff <= credits_ff + (QUEUE_PTR_W+1)'(accept) - (QUEUE_PTR_W+1)'(pop);
         count_ff   <= count_ff + (QUEUE_PTR_W+1)'(back_valid) - (QUEUE_PTR_W+1)'(pop);
         if (back_valid) begin
            wptr_ff <= wptr_ff + 1'b1;
         end
         if (pop) begin
            rptr_ff <= rptr_ff + 1'b1;
         end
      end
      if (back_valid) begin
         queue_ff[wptr_ff] <= back_data;
      end
   end

   a_credit_bound: assert property (@(posedge clock) disable iff (reset)
      credits_ff <= (QUEUE_PTR_W+1)'(QUEUE_DEPTH))
      else $error("credit count above queue depth");

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      back_valid |-> (count_ff < (QUEUE_PTR_W+1)'(QUEUE_DEPTH)) || pop)
      else $error("result queue overflow");

   a_count_le_credits: assert property (@(posedge clock) disable iff (reset)
      count_ff <= credits_ff)
      else $error("more results queued than requests accepted");

endmodule
